/* rtl/lavm_pkg.sv */
// Shared constants and types for the look-at view matrix unit.
// No dependencies; imported by every module of the unit.
`default_nettype none
package lavm_pkg;

  // Default fraction width of the fixed-point formats
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int POS_W   = 32;
  localparam int ELEM_W  = 18;
  localparam int SHIFT_W = 32;

  // Latencies of the fixed-length sections
  localparam int UP_LAT    = 4;
  localparam int SHIFT_LAT = 4;

  // Matrix row codes
  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_DIR   = 2'd2
  } row_t;

  // Latency of the normalize section: input, five shift steps, square, sum,
  // 32 root steps, divide setup, one divide step per quotient bit, sign
  function automatic int norm_lat(input int frac);
    return frac + 43;
  endfunction

endpackage
`default_nettype wire

/* rtl/lavm_norm.sv */
// Vector normalizer: power-of-two prescale, sum of squares, 32-step integer
// square root and rounded restoring divide, all as pipeline stages. Uses lavm_pkg.
`default_nettype none
module lavm_norm import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [2:0]                  in_neg,
  input  logic [31:0]                 in_mag [0:2],
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_elem [0:2]
);

  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 34;
  localparam int LAT = norm_lat(FRAC_BITS);

  logic [LAT-1:0] vld;

  logic [31:0] mx_s  [0:4];
  logic [31:0] m_s   [0:5][0:2];
  logic [2:0]  neg_s [0:5];

  logic [63:0] sq    [0:2];
  logic [31:0] m_q   [0:2];
  logic [2:0]  neg_q;

  logic [35:0] rem   [0:32];
  logic [31:0] root  [0:32];
  logic [63:0] xr    [0:32];
  logic [31:0] m_t   [0:32][0:2];
  logic [2:0]  neg_t [0:32];

  logic [NW-1:0] nr  [0:QW][0:2];
  logic [NW-1:0] dn  [0:QW];
  logic [QW-1:0] q   [0:QW][0:2];
  logic [2:0]    ng  [0:QW];

  logic [31:0] mx_in;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // Largest magnitude
  always_comb begin
    mx_in = in_mag[0];
    if (in_mag[1] > mx_in) mx_in = in_mag[1];
    if (in_mag[2] > mx_in) mx_in = in_mag[2];
  end

  // Capture request
  always_ff @(posedge clk) begin
    mx_s[0]  <= mx_in;
    neg_s[0] <= in_neg;
    for (int i = 0; i < 3; i++) m_s[0][i] <= in_mag[i];
  end

  // Prescale so the largest magnitude reaches bit 30
  for (genvar j = 0; j < 5; j++) begin : g_pre
    localparam int S = 16 >> j;
    logic hit;
    assign hit = !mx_s[j][31] && (mx_s[j][30 -: S] == '0);
    always_ff @(posedge clk) begin
      neg_s[j+1] <= neg_s[j];
      if (hit) begin
        for (int i = 0; i < 3; i++) m_s[j+1][i] <= m_s[j][i] << S;
      end else begin
        for (int i = 0; i < 3; i++) m_s[j+1][i] <= m_s[j][i];
      end
    end
    // Track the largest magnitude for the remaining steps
    if (j < 4) begin : g_mx
      always_ff @(posedge clk) begin
        mx_s[j+1] <= hit ? mx_s[j] << S : mx_s[j];
      end
    end
  end

  // Square each component
  always_ff @(posedge clk) begin
    neg_q <= neg_s[5];
    for (int i = 0; i < 3; i++) begin
      m_q[i] <= m_s[5][i];
      sq[i]  <= 64'(m_s[5][i]) * 64'(m_s[5][i]);
    end
  end

  // Sum squares and seed the root
  always_ff @(posedge clk) begin
    xr[0]    <= sq[0] + sq[1] + sq[2];
    rem[0]   <= '0;
    root[0]  <= '0;
    neg_t[0] <= neg_q;
    for (int i = 0; i < 3; i++) m_t[0][i] <= m_q[i];
  end

  // One root bit per stage
  for (genvar t = 0; t < 32; t++) begin : g_sqrt
    logic [35:0] rem_n;
    logic [35:0] trial;
    logic        ge;
    assign rem_n = {rem[t][33:0], xr[t][63:62]};
    assign trial = {2'b00, root[t], 2'b01};
    assign ge    = rem_n >= trial;
    always_ff @(posedge clk) begin
      rem[t+1]   <= ge ? rem_n - trial : rem_n;
      root[t+1]  <= {root[t][30:0], ge};
      xr[t+1]    <= {xr[t][61:0], 2'b00};
      neg_t[t+1] <= neg_t[t];
      for (int i = 0; i < 3; i++) m_t[t+1][i] <= m_t[t][i];
    end
  end

  // Set up rounded divide: (2*m*2^F + len) / (2*len)
  always_ff @(posedge clk) begin
    dn[0] <= NW'(root[32]) << 1;
    ng[0] <= neg_t[32];
    for (int i = 0; i < 3; i++) begin
      nr[0][i] <= (NW'(m_t[32][i]) << (FRAC_BITS + 1)) + NW'(root[32]);
      q[0][i]  <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int J = FRAC_BITS - t;
    logic [NW-1:0] dj;
    logic [2:0]    ge;
    assign dj = dn[t] << J;
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = nr[t][i] >= dj;
    end
    always_ff @(posedge clk) begin
      dn[t+1] <= dn[t];
      ng[t+1] <= ng[t];
      for (int i = 0; i < 3; i++) begin
        nr[t+1][i] <= ge[i] ? nr[t][i] - dj : nr[t][i];
        q[t+1][i]  <= {q[t][i][QW-2:0], ge[i]};
      end
    end
  end

  // Apply signs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ng[QW][i]) out_elem[i] <= -$signed({1'b0, q[QW][i]});
      else           out_elem[i] <= $signed({1'b0, q[QW][i]});
    end
  end

endmodule
`default_nettype wire

/* rtl/lavm_up.sv */
// Up vector as cross(direction, right) with rounding and clamp to [-1, 1];
// carries right and direction alongside. Uses lavm_pkg.
`default_nettype none
module lavm_up import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [FRAC_BITS+1:0] in_d [0:2],
  input  logic signed [FRAC_BITS+1:0] in_r [0:2],
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_r [0:2],
  output logic signed [FRAC_BITS+1:0] out_u [0:2],
  output logic signed [FRAC_BITS+1:0] out_d [0:2]
);

  localparam int EW = FRAC_BITS + 2;
  localparam int PW = 2 * EW;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;

  logic [UP_LAT-1:0] vld;
  logic signed [EW-1:0] d_p [0:UP_LAT-1][0:2];
  logic signed [EW-1:0] r_p [0:UP_LAT-1][0:2];

  logic signed [PW-1:0] pa, pb, pc, pe;
  logic signed [PW-1:0] s   [0:2];
  logic        [PW-1:0] rm  [0:2];
  logic        [2:0]    sg;
  logic        [PW-1:0] mag [0:2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[UP_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[UP_LAT-1];

  // Carry right and direction
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_p[0][i] <= in_d[i];
      r_p[0][i] <= in_r[i];
      for (int k = 1; k < UP_LAT; k++) begin
        d_p[k][i] <= d_p[k-1][i];
        r_p[k][i] <= r_p[k-1][i];
      end
    end
  end

  // Products
  always_ff @(posedge clk) begin
    pa <= in_d[1] * in_r[2];
    pb <= in_d[2] * in_r[0];
    pc <= in_d[0] * in_r[2];
    pe <= in_d[1] * in_r[0];
  end

  // Combine into cross product terms
  always_ff @(posedge clk) begin
    s[0] <= pa;
    s[1] <= pb - pc;
    s[2] <= -pe;
  end

  // Round magnitude half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = s[i][PW-1] ? PW'(-s[i]) : PW'(s[i]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rm[i] <= (mag[i] + HALF) >> FRAC_BITS;
      sg[i] <= s[i][PW-1];
    end
  end

  // Clamp and restore sign
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (rm[i] > ONE) begin
        out_u[i] <= sg[i] ? -$signed(EW'(ONE)) : $signed(EW'(ONE));
      end else begin
        out_u[i] <= sg[i] ? -$signed(EW'(rm[i])) : $signed(EW'(rm[i]));
      end
    end
  end

  assign out_r = r_p[UP_LAT-1];
  assign out_d = d_p[UP_LAT-1];

endmodule
`default_nettype wire

/* rtl/lavm_shift.sv */
// Translation column: -dot(row, position) per row, rounded and saturated
// to 32 bits; carries the rows and degenerate flag. Uses lavm_pkg.
`default_nettype none
module lavm_shift import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [FRAC_BITS+1:0] in_row [0:2][0:2],
  input  logic signed [POS_W-1:0]     in_pos [0:2],
  input  logic                        in_degen,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_row [0:2][0:2],
  output logic signed [SHIFT_W-1:0]   out_shift [0:2],
  output logic [2:0]                  out_sat,
  output logic                        out_degen
);

  localparam int EW = FRAC_BITS + 2;
  localparam int AW = EW + POS_W;
  localparam int SW = AW + 2;
  localparam logic [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
  localparam logic [SW-1:0] POS_LIM = SW'(64'h7FFF_FFFF);
  localparam logic [SW-1:0] NEG_LIM = SW'(64'h8000_0000);

  logic [SHIFT_LAT-1:0] vld;
  logic signed [EW-1:0] row_p [0:SHIFT_LAT-1][0:2][0:2];
  logic [SHIFT_LAT-1:0] dg_p;

  logic signed [AW-1:0] pr  [0:2][0:2];
  logic signed [SW-1:0] acc [0:2];
  logic        [SW-1:0] mag [0:2];
  logic        [SW-1:0] rm  [0:2];
  logic        [2:0]    sn;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SHIFT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[SHIFT_LAT-1];

  // Carry rows and flag
  always_ff @(posedge clk) begin
    dg_p <= {dg_p[SHIFT_LAT-2:0], in_degen};
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        row_p[0][k][i] <= in_row[k][i];
        for (int t = 1; t < SHIFT_LAT; t++) row_p[t][k][i] <= row_p[t-1][k][i];
      end
    end
  end

  // Products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) pr[k][i] <= in_row[k][i] * in_pos[i];
    end
  end

  // Dot products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      acc[k] <= SW'(pr[k][0]) + SW'(pr[k][1]) + SW'(pr[k][2]);
    end
  end

  // Round magnitude; result is negative when the dot is positive
  always_comb begin
    for (int k = 0; k < 3; k++) mag[k] = acc[k][SW-1] ? SW'(-acc[k]) : SW'(acc[k]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rm[k] <= (mag[k] + HALF) >> FRAC_BITS;
      sn[k] <= !acc[k][SW-1] && (acc[k] != '0);
    end
  end

  // Saturate to 32 bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (sn[k]) begin
        if (rm[k] > NEG_LIM) begin
          out_shift[k] <= 32'sh8000_0000;
          out_sat[k]   <= 1'b1;
        end else begin
          out_shift[k] <= $signed(~rm[k][31:0] + 32'd1);
          out_sat[k]   <= 1'b0;
        end
      end else begin
        if (rm[k] > POS_LIM) begin
          out_shift[k] <= 32'sh7FFF_FFFF;
          out_sat[k]   <= 1'b1;
        end else begin
          out_shift[k] <= $signed(rm[k][31:0]);
          out_sat[k]   <= 1'b0;
        end
      end
    end
  end

  assign out_row   = row_p[SHIFT_LAT-1];
  assign out_degen = dg_p[SHIFT_LAT-1];

endmodule
`default_nettype wire

/* rtl/look_at_view_matrix_unit.sv */
// Top level of the look-at view matrix unit (world up +Y).
// Depends on lavm_pkg, lavm_norm, lavm_up and lavm_shift.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   request  | start / busy         | pos_x/y/z, front_x/y/z
//   result   | valid                | row_index, elem_x/y/z, shift, saturated,
//            |                      | degenerate, last
//
// Requests are throttled: the three rows leave one per cycle on the
// single result port, so busy is raised after each accepted request.
// Row 0 follows the normalize, up, translation and output registers
// (normalize dominated by the 32 root steps and FRAC_BITS + 1 divide steps).
// rst clears only the valid bits, the busy counter and the row sequencer.
// The receiver cannot stall; the pipeline never holds.
`default_nettype none
module look_at_view_matrix_unit import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic signed [POS_W-1:0]   pos_z,
  input  logic signed [POS_W-1:0]   front_x,
  input  logic signed [POS_W-1:0]   front_y,
  input  logic signed [POS_W-1:0]   front_z,
  output logic                      valid,
  output logic [1:0]                row_index,
  output logic signed [ELEM_W-1:0]  elem_x,
  output logic signed [ELEM_W-1:0]  elem_y,
  output logic signed [ELEM_W-1:0]  elem_z,
  output logic signed [SHIFT_W-1:0] shift,
  output logic                      saturated,
  output logic                      degenerate,
  output logic                      last
);

  localparam int EW   = FRAC_BITS + 2;
  localparam int NLAT = norm_lat(FRAC_BITS);
  localparam int DLY  = NLAT + UP_LAT;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    degen;
  } pose_t;

  logic       accept;
  logic [1:0] hold_cnt;

  logic [31:0] fx_mag, fy_mag, fz_mag;
  logic [2:0]  d_neg, r_neg;
  logic [31:0] d_mag [0:2];
  logic [31:0] r_mag [0:2];

  logic                 dn_valid, rn_valid;
  logic signed [EW-1:0] d_n [0:2];
  logic signed [EW-1:0] r_n [0:2];

  logic                 up_valid;
  logic signed [EW-1:0] up_r [0:2];
  logic signed [EW-1:0] up_u [0:2];
  logic signed [EW-1:0] up_d [0:2];

  pose_t dl [0:DLY-1];

  logic signed [EW-1:0]    rows [0:2][0:2];
  logic signed [POS_W-1:0] pos_v [0:2];

  logic                      sh_valid;
  logic signed [EW-1:0]      sh_row [0:2][0:2];
  logic signed [SHIFT_W-1:0] sh_val [0:2];
  logic [2:0]                sh_sat;
  logic                      sh_degen;

  logic [ELEM_W-1:0]  hold_e  [0:2][0:2];
  logic [SHIFT_W-1:0] hold_sh [0:2];
  logic [2:0]         hold_sat;
  logic               hold_dg;
  logic               pending;
  row_t               nxt;

  // Throttle requests: accept only when not busy
  assign accept = start && !busy;
  assign busy   = hold_cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 2'd0;
    end else if (accept) begin
      hold_cnt <= 2'd2;
    end else if (hold_cnt != 2'd0) begin
      hold_cnt <= hold_cnt - 2'd1;
    end
  end

  // Sign and magnitude of the vectors to normalize
  assign fx_mag = front_x[POS_W-1] ? ~front_x + 32'd1 : front_x;
  assign fy_mag = front_y[POS_W-1] ? ~front_y + 32'd1 : front_y;
  assign fz_mag = front_z[POS_W-1] ? ~front_z + 32'd1 : front_z;

  // Direction is -front
  assign d_neg = {!front_z[POS_W-1] && (front_z != '0),
                  !front_y[POS_W-1] && (front_y != '0),
                  !front_x[POS_W-1] && (front_x != '0)};
  assign d_mag[0] = fx_mag;
  assign d_mag[1] = fy_mag;
  assign d_mag[2] = fz_mag;

  // Right points along (-front_z, 0, front_x)
  assign r_neg = {front_x[POS_W-1], 1'b0, !front_z[POS_W-1] && (front_z != '0)};
  assign r_mag[0] = fz_mag;
  assign r_mag[1] = 32'd0;
  assign r_mag[2] = fx_mag;

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_d (
    .clk(clk), .rst(rst), .in_valid(accept), .in_neg(d_neg), .in_mag(d_mag),
    .out_valid(dn_valid), .out_elem(d_n)
  );

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_r (
    .clk(clk), .rst(rst), .in_valid(accept), .in_neg(r_neg), .in_mag(r_mag),
    .out_valid(rn_valid), .out_elem(r_n)
  );

  lavm_up #(.FRAC_BITS(FRAC_BITS)) u_up (
    .clk(clk), .rst(rst), .in_valid(dn_valid && rn_valid), .in_d(d_n), .in_r(r_n),
    .out_valid(up_valid), .out_r(up_r), .out_u(up_u), .out_d(up_d)
  );

  // Hold position and degenerate flag alongside the vector math
  always_ff @(posedge clk) begin
    dl[0] <= '{x: pos_x, y: pos_y, z: pos_z,
               degen: (front_x == '0) && (front_z == '0)};
    for (int i = 1; i < DLY; i++) dl[i] <= dl[i-1];
  end

  // Drop entries of a degenerate request
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rows[ROW_RIGHT][i] = dl[DLY-1].degen ? '0 : up_r[i];
      rows[ROW_UP][i]    = dl[DLY-1].degen ? '0 : up_u[i];
      rows[ROW_DIR][i]   = dl[DLY-1].degen ? '0 : up_d[i];
    end
    pos_v[0] = dl[DLY-1].x;
    pos_v[1] = dl[DLY-1].y;
    pos_v[2] = dl[DLY-1].z;
  end

  lavm_shift #(.FRAC_BITS(FRAC_BITS)) u_shift (
    .clk(clk), .rst(rst), .in_valid(up_valid), .in_row(rows), .in_pos(pos_v),
    .in_degen(dl[DLY-1].degen), .out_valid(sh_valid), .out_row(sh_row),
    .out_shift(sh_val), .out_sat(sh_sat), .out_degen(sh_degen)
  );

  // Hold rows for the sequencer
  always_ff @(posedge clk) begin
    if (sh_valid) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) hold_e[k][i] <= ELEM_W'(sh_row[k][i]);
        hold_sh[k] <= sh_val[k];
      end
      hold_sat <= sh_sat;
      hold_dg  <= sh_degen;
    end
  end

  // Emit the three rows on consecutive cycles
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
      nxt     <= ROW_UP;
    end else if (sh_valid) begin
      valid   <= 1'b1;
      pending <= 1'b1;
      nxt     <= ROW_UP;
    end else if (pending) begin
      valid <= 1'b1;
      unique case (nxt)
        ROW_UP:  nxt <= ROW_DIR;
        default: begin
          nxt     <= ROW_UP;
          pending <= 1'b0;
        end
      endcase
    end else begin
      valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (sh_valid) begin
      row_index  <= ROW_RIGHT;
      elem_x     <= ELEM_W'(sh_row[ROW_RIGHT][0]);
      elem_y     <= ELEM_W'(sh_row[ROW_RIGHT][1]);
      elem_z     <= ELEM_W'(sh_row[ROW_RIGHT][2]);
      shift      <= sh_val[ROW_RIGHT];
      saturated  <= sh_sat[ROW_RIGHT];
      degenerate <= sh_degen;
      last       <= 1'b0;
    end else if (pending) begin
      row_index  <= nxt;
      elem_x     <= hold_e[nxt][0];
      elem_y     <= hold_e[nxt][1];
      elem_z     <= hold_e[nxt][2];
      shift      <= hold_sh[nxt];
      saturated  <= hold_sat[nxt];
      degenerate <= hold_dg;
      last       <= nxt == ROW_DIR;
    end
  end

endmodule
`default_nettype wire
